// ===== design/hct_pkg.sv =====
// hct_pkg: shared codes, states, datapath commands and status for the Huffman tree codec.
// Used by hct_ctrl, hct_dp, huffman_tree_codec and hct_chk; depends on nothing.
`timescale 1ns / 1ps
package hct_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 2;
  localparam int CFG_W      = 7;
  localparam int SLOT_W     = 7;
  localparam int SYM_W      = 8;
  localparam int WIN_W      = 16;
  localparam int CODE_W     = 63;
  localparam int LEN_W      = 6;

  localparam logic [IN_USER_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [IN_USER_W-1:0] OP_BUILD  = 3'd1;
  localparam logic [IN_USER_W-1:0] OP_ENCODE = 3'd2;
  localparam logic [IN_USER_W-1:0] OP_DECODE = 3'd3;
  localparam logic [IN_USER_W-1:0] OP_END    = 3'd4;

  localparam logic [OUT_USER_W-1:0] KIND_BUILD  = 2'd0;
  localparam logic [OUT_USER_W-1:0] KIND_CODE   = 2'd1;
  localparam logic [OUT_USER_W-1:0] KIND_SYMBOL = 2'd2;
  localparam logic [OUT_USER_W-1:0] KIND_END    = 2'd3;

  localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_B_SCAN,
    ST_B_WR2,
    ST_E_SCAN,
    ST_E_CHK,
    ST_E_STEP,
    ST_D_CHK1,
    ST_D_CHK2,
    ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LOAD,
    CMD_B_INIT,
    CMD_SCAN,
    CMD_B_WR1,
    CMD_B_WR2,
    CMD_E_INIT,
    CMD_E_RDP,
    CMD_E_CHK,
    CMD_E_STEP,
    CMD_E_MISS,
    CMD_E_FOUND,
    CMD_D_RD1,
    CMD_D_MISS,
    CMD_D_CHK1,
    CMD_D_LEAF,
    CMD_END,
    CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic [IN_USER_W-1:0] op;
    logic                 scan_done;
    logic                 hit;
    logic                 walk_stop;
    logic                 next_zero;
    logic                 is_leaf;
    logic                 last_merge;
    logic                 out_free;
  } stat_t;

endpackage

// ===== design/hct_ctrl.sv =====
// hct_ctrl: sequencer for load, build, encode, decode and end-of-stream items.
// Depends on hct_pkg; drives hct_dp through dp_cmd_t and reads stat_t.
`timescale 1ns / 1ps
module hct_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  hct_pkg::stat_t   stat,
  output hct_pkg::dp_cmd_t act
);

  hct_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hct_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = hct_pkg::ST_DISP;
      end
      hct_pkg::ST_DISP: begin
        if (stat.op == hct_pkg::OP_BUILD) state_next = hct_pkg::ST_B_SCAN;
        else if (stat.op == hct_pkg::OP_ENCODE) state_next = hct_pkg::ST_E_SCAN;
        else if (stat.op == hct_pkg::OP_DECODE) state_next = hct_pkg::ST_D_CHK1;
        else if (stat.op == hct_pkg::OP_END) state_next = hct_pkg::ST_EMIT;
        else state_next = hct_pkg::ST_IDLE;
      end
      hct_pkg::ST_B_SCAN: begin
        if (stat.scan_done) state_next = hct_pkg::ST_B_WR2;
      end
      hct_pkg::ST_B_WR2: begin
        state_next = stat.last_merge ? hct_pkg::ST_EMIT : hct_pkg::ST_B_SCAN;
      end
      hct_pkg::ST_E_SCAN: begin
        if (stat.scan_done) state_next = stat.hit ? hct_pkg::ST_E_CHK : hct_pkg::ST_EMIT;
      end
      hct_pkg::ST_E_CHK: begin
        state_next = stat.walk_stop ? hct_pkg::ST_EMIT : hct_pkg::ST_E_STEP;
      end
      hct_pkg::ST_E_STEP: begin
        state_next = hct_pkg::ST_E_CHK;
      end
      hct_pkg::ST_D_CHK1: begin
        state_next = stat.next_zero ? hct_pkg::ST_IDLE : hct_pkg::ST_D_CHK2;
      end
      hct_pkg::ST_D_CHK2: begin
        state_next = stat.is_leaf ? hct_pkg::ST_EMIT : hct_pkg::ST_IDLE;
      end
      hct_pkg::ST_EMIT: begin
        if (stat.out_free) state_next = hct_pkg::ST_IDLE;
      end
      default: state_next = hct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act      = hct_pkg::CMD_NONE;
    s_tready = 1'b0;
    unique case (state)
      hct_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) act = hct_pkg::CMD_LATCH;
      end
      hct_pkg::ST_DISP: begin
        if (stat.op == hct_pkg::OP_LOAD) act = hct_pkg::CMD_LOAD;
        else if (stat.op == hct_pkg::OP_BUILD) act = hct_pkg::CMD_B_INIT;
        else if (stat.op == hct_pkg::OP_ENCODE) act = hct_pkg::CMD_E_INIT;
        else if (stat.op == hct_pkg::OP_DECODE) act = hct_pkg::CMD_D_RD1;
        else if (stat.op == hct_pkg::OP_END) act = hct_pkg::CMD_END;
        else act = hct_pkg::CMD_NONE;
      end
      hct_pkg::ST_B_SCAN: begin
        act = stat.scan_done ? hct_pkg::CMD_B_WR1 : hct_pkg::CMD_SCAN;
      end
      hct_pkg::ST_B_WR2: begin
        act = hct_pkg::CMD_B_WR2;
      end
      hct_pkg::ST_E_SCAN: begin
        if (!stat.scan_done) act = hct_pkg::CMD_SCAN;
        else act = stat.hit ? hct_pkg::CMD_E_RDP : hct_pkg::CMD_E_MISS;
      end
      hct_pkg::ST_E_CHK: begin
        act = stat.walk_stop ? hct_pkg::CMD_E_FOUND : hct_pkg::CMD_E_CHK;
      end
      hct_pkg::ST_E_STEP: begin
        act = hct_pkg::CMD_E_STEP;
      end
      hct_pkg::ST_D_CHK1: begin
        act = stat.next_zero ? hct_pkg::CMD_D_MISS : hct_pkg::CMD_D_CHK1;
      end
      hct_pkg::ST_D_CHK2: begin
        act = stat.is_leaf ? hct_pkg::CMD_D_LEAF : hct_pkg::CMD_NONE;
      end
      hct_pkg::ST_EMIT: begin
        if (stat.out_free) act = hct_pkg::CMD_EMIT;
      end
      default: act = hct_pkg::CMD_NONE;
    endcase
  end

endmodule

// ===== design/hct_dp.sv =====
// hct_dp: node table memories, min-pair scan, code walk, decode pointer and output register.
// Depends on hct_pkg; commanded by hct_ctrl.
`timescale 1ns / 1ps
module hct_dp #(
  parameter int MAX_SYMBOLS = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hct_pkg::dp_cmd_t                    act,
  output hct_pkg::stat_t                      stat,
  input  logic                                cfg_we,
  input  logic [hct_pkg::CFG_W-1:0]           cfg_data,
  input  logic [hct_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [hct_pkg::IN_USER_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hct_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [hct_pkg::OUT_USER_W-1:0]      m_tuser
);

  localparam int NODES  = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_W = $clog2(NODES + 1);
  localparam int NW     = $clog2(MAX_SYMBOLS + 1);
  localparam int LW     = $clog2(MAX_SYMBOLS);
  localparam int WW     = WEIGHT_BITS + 6;
  localparam int WIN    = (WEIGHT_BITS < hct_pkg::WIN_W) ? WEIGHT_BITS : hct_pkg::WIN_W;

  // node table and leaf symbols
  logic [WW-1:0]     wmem [0:NODES];
  logic [NODE_W-1:0] lmem [0:NODES];
  logic [NODE_W-1:0] rmem [0:NODES];
  logic [NODE_W-1:0] pmem [0:NODES];
  logic [hct_pkg::SYM_W-1:0] smem [0:MAX_SYMBOLS-1];
  logic [NODES:0]    cvld, pvld, used;

  logic [WW-1:0]     wrd;
  logic [NODE_W-1:0] lrd, rrd, prd;
  logic [hct_pkg::SYM_W-1:0] srd;
  logic              cv_q, pv_q;

  logic [NODE_W-1:0] w_ra, c_ra, p_ra;
  logic [LW-1:0]     s_ra;

  // latched item
  logic [hct_pkg::IN_USER_W-1:0] op_q;
  logic [hct_pkg::SLOT_W-1:0]    slot_q;
  logic [hct_pkg::SYM_W-1:0]     sym_q;
  logic [hct_pkg::WIN_W-1:0]     win_q;
  logic                          bit_q;

  logic [NW-1:0]     n, nsat;
  logic [NODE_W-1:0] dpos, root, nroot;

  // scan and walk registers
  logic [NODE_W-1:0] idx, lim, rd_idx, cur, a, b, leaf, c, p;
  logic              rd_ok, have1, have2, hit;
  logic [WW-1:0]     w1, w2;
  logic [hct_pkg::CODE_W-1:0] code;
  logic [hct_pkg::LEN_W-1:0]  len;

  // pending result
  logic [hct_pkg::OUT_USER_W-1:0] res_kind;
  logic [hct_pkg::SYM_W-1:0]      res_sym;
  logic [hct_pkg::CODE_W-1:0]     res_code;
  logic [hct_pkg::LEN_W-1:0]      res_len;
  logic                           res_found, res_inc;

  logic [NODE_W-1:0] lg, rg, pg, nxt;
  logic              scan_done, slot_ok, out_free;

  assign lg   = cv_q ? lrd : '0;
  assign rg   = cv_q ? rrd : '0;
  assign pg   = pv_q ? prd : '0;
  assign nxt  = bit_q ? rg : lg;
  assign root = NODE_W'({n, 1'b0} - 1'b1);
  assign scan_done = (idx > lim) && !rd_ok;
  assign out_free  = !m_tvalid || m_tready;
  assign slot_ok   = (slot_q != '0) && ({1'b0, slot_q} <= (hct_pkg::SLOT_W + 1)'(n));

  always_comb begin
    if (cfg_data < 7'd2) nsat = NW'(2);
    else if (cfg_data > 7'(MAX_SYMBOLS)) nsat = NW'(MAX_SYMBOLS);
    else nsat = NW'(cfg_data);
  end
  assign nroot = NODE_W'({nsat, 1'b0} - 1'b1);

  always_comb begin
    stat.op         = op_q;
    stat.scan_done  = scan_done;
    stat.hit        = hit;
    stat.walk_stop  = (pg == '0) || (len == hct_pkg::LEN_MAX);
    stat.next_zero  = (nxt == '0);
    stat.is_leaf    = (lg == '0) && (rg == '0);
    stat.last_merge = (cur == root);
    stat.out_free   = out_free;
  end

  // read addresses
  always_comb begin
    w_ra = idx;
    if (act == hct_pkg::CMD_E_CHK) c_ra = pg;
    else if (act == hct_pkg::CMD_D_CHK1) c_ra = nxt;
    else c_ra = dpos;
    p_ra = (act == hct_pkg::CMD_E_STEP) ? p : leaf;
    s_ra = (act == hct_pkg::CMD_D_CHK1) ? LW'(nxt - 1'b1) : LW'(idx - 1'b1);
  end

  // memories
  always_ff @(posedge clk) begin
    if (act == hct_pkg::CMD_LOAD && slot_ok) begin
      wmem[NODE_W'(slot_q)] <= WW'(win_q[WIN-1:0]);
      smem[LW'(slot_q - 1'b1)] <= sym_q;
    end else if (act == hct_pkg::CMD_B_WR1) begin
      wmem[cur] <= w1 + w2;
    end
    if (act == hct_pkg::CMD_B_WR1) begin
      lmem[cur] <= a;
      rmem[cur] <= b;
      pmem[a]   <= cur;
    end else if (act == hct_pkg::CMD_B_WR2) begin
      pmem[b]   <= cur;
    end
    wrd  <= wmem[w_ra];
    srd  <= smem[s_ra];
    lrd  <= lmem[c_ra];
    rrd  <= rmem[c_ra];
    prd  <= pmem[p_ra];
    cv_q <= cvld[c_ra];
    pv_q <= pvld[p_ra];
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= NW'(2);
      dpos     <= NODE_W'(3);
      cvld     <= '0;
      pvld     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        n    <= nsat;
        dpos <= nroot;
      end else begin
        unique case (act)
          hct_pkg::CMD_B_INIT: begin
            pvld <= '0;
            for (int k = 1; k <= NODES; k++) begin
              if (k <= int'(n)) cvld[k] <= 1'b0;
            end
          end
          hct_pkg::CMD_B_WR1: begin
            cvld[cur] <= 1'b1;
            pvld[a]   <= 1'b1;
          end
          hct_pkg::CMD_B_WR2: begin
            pvld[b] <= 1'b1;
            if (cur == root) dpos <= root;
          end
          hct_pkg::CMD_D_MISS, hct_pkg::CMD_D_LEAF, hct_pkg::CMD_END: dpos <= root;
          hct_pkg::CMD_D_CHK1: dpos <= nxt;
          default: ;
        endcase
      end
      if (act == hct_pkg::CMD_EMIT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (act)
      hct_pkg::CMD_LATCH: begin
        op_q   <= s_tuser;
        slot_q <= s_tdata[6:0];
        sym_q  <= s_tdata[14:7];
        win_q  <= s_tdata[30:15];
        bit_q  <= s_tdata[31];
      end
      hct_pkg::CMD_B_INIT: begin
        used  <= '0;
        cur   <= NODE_W'(n) + 1'b1;
        lim   <= NODE_W'(n);
        idx   <= NODE_W'(1);
        rd_ok <= 1'b0;
        have1 <= 1'b0;
        have2 <= 1'b0;
      end
      hct_pkg::CMD_E_INIT: begin
        lim   <= NODE_W'(n);
        idx   <= NODE_W'(1);
        rd_ok <= 1'b0;
        hit   <= 1'b0;
      end
      hct_pkg::CMD_SCAN: begin
        if (rd_ok) begin
          if (op_q == hct_pkg::OP_BUILD) begin
            if (!used[rd_idx]) begin
              if (!have1 || wrd < w1) begin
                b     <= a;
                w2    <= w1;
                have2 <= have1;
                a     <= rd_idx;
                w1    <= wrd;
                have1 <= 1'b1;
              end else if (!have2 || wrd < w2) begin
                b     <= rd_idx;
                w2    <= wrd;
                have2 <= 1'b1;
              end
            end
          end else if (!hit && srd == sym_q) begin
            hit  <= 1'b1;
            leaf <= rd_idx;
          end
        end
        if (idx <= lim) begin
          rd_idx <= idx;
          rd_ok  <= 1'b1;
          idx    <= idx + 1'b1;
        end else begin
          rd_ok <= 1'b0;
        end
      end
      hct_pkg::CMD_B_WR1: begin
        used[a] <= 1'b1;
        used[b] <= 1'b1;
      end
      hct_pkg::CMD_B_WR2: begin
        if (cur == root) begin
          res_kind  <= hct_pkg::KIND_BUILD;
          res_sym   <= '0;
          res_code  <= '0;
          res_len   <= '0;
          res_found <= 1'b0;
          res_inc   <= 1'b0;
        end else begin
          cur   <= cur + 1'b1;
          lim   <= cur;
          idx   <= NODE_W'(1);
          have1 <= 1'b0;
          have2 <= 1'b0;
        end
      end
      hct_pkg::CMD_E_RDP: begin
        c    <= leaf;
        code <= '0;
        len  <= '0;
      end
      hct_pkg::CMD_E_CHK: p <= pg;
      hct_pkg::CMD_E_STEP: begin
        if (lg != c) code <= code | (hct_pkg::CODE_W'(1) << len);
        len <= len + 1'b1;
        c   <= p;
      end
      hct_pkg::CMD_E_MISS, hct_pkg::CMD_E_FOUND: begin
        res_kind  <= hct_pkg::KIND_CODE;
        res_sym   <= '0;
        res_code  <= (act == hct_pkg::CMD_E_FOUND) ? code : '0;
        res_len   <= (act == hct_pkg::CMD_E_FOUND) ? len : '0;
        res_found <= (act == hct_pkg::CMD_E_FOUND);
        res_inc   <= 1'b0;
      end
      hct_pkg::CMD_D_LEAF: begin
        res_kind  <= hct_pkg::KIND_SYMBOL;
        res_sym   <= (dpos <= NODE_W'(MAX_SYMBOLS)) ? srd : '0;
        res_code  <= '0;
        res_len   <= '0;
        res_found <= 1'b0;
        res_inc   <= 1'b0;
      end
      hct_pkg::CMD_END: begin
        res_kind  <= hct_pkg::KIND_END;
        res_sym   <= '0;
        res_code  <= '0;
        res_len   <= '0;
        res_found <= 1'b0;
        res_inc   <= (dpos != root);
      end
      hct_pkg::CMD_EMIT: begin
        m_tuser <= res_kind;
        m_tdata <= {1'b0, res_inc, res_found, res_len, res_code, res_sym};
      end
      default: ;
    endcase
  end

endmodule

// ===== design/huffman_tree_codec.sv =====
// huffman_tree_codec: top level of the Huffman tree build / encode / decode block.
// Depends on hct_pkg, hct_ctrl and hct_dp.
//
//  channel | dir | tdata / data                          | tuser
//  s       | in  | slot, symbol, weight, code_bit        | operation
//  m       | out | symbol, code, length, found, incomp.  | kind
//  cfg     | in  | symbol_count (7 bits), cfg_we strobe  | -
//
// One item at a time; an item with a result then waits for a free output register.
// Build: each merge rescans the weight memory through its single read port,
// one node a cycle. Encode scans the symbol memory for the leaf, then walks
// up the parent memory one code bit at a time.
// Reset sets n = 2, decode pointer = 3, clears node valid bits and output beat; no sweep.
// A stalled result beat holds in the output register while the next item runs.
`timescale 1ns / 1ps
module huffman_tree_codec #(
  parameter int MAX_SYMBOLS = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,  // symbol_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // leaf_slot[6:0], symbol[14:7], weight[30:15], code_bit[31]
  input  logic [2:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // out_symbol[7:0], code_value[70:8], code_length[76:71],
                                 // found[77], incomplete[78], zero[79]
  output logic [1:0]  m_tuser    // kind
);

  hct_pkg::stat_t   stat;
  hct_pkg::dp_cmd_t act;

  hct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .act      (act)
  );

  hct_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .act      (act),
    .stat     (stat),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== design/hct_chk.sv =====
// hct_chk: port-level checks for huffman_tree_codec, attached by bind.
// Depends on hct_pkg for result kinds.
`timescale 1ns / 1ps
module hct_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken before first was dispatched");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat out of reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == hct_pkg::KIND_CODE && !m_tdata[77] |->
      m_tdata[76:8] == '0)
    else $error("encode miss carries code bits");

endmodule

bind huffman_tree_codec hct_chk u_hct_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
